FILE: src/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared constants and controller/datapath interface types for the
// rectilinear path position block.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam int COORD_BITS       = 16;
    localparam int LEN_BITS         = 28;
    localparam int TIME_BITS        = 31;
    localparam int IDX_BITS         = 10;
    localparam int CNT_BITS         = 11;
    localparam int STEP_BITS        = $clog2(TIME_BITS);
    localparam int DEF_MAX_VERTICES = 1024;

    localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(4);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ld_read;
        logic ld_write;
        logic ld_close;
        logic div_init;
        logic div_step;
        logic srch_init;
        logic srch_read;
        logic srch_update;
        logic rd_lo;
        logic rd_nx;
        logic pos_x;
        logic pos_y;
        logic out_load;
        logic out_err;
    } rpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic ld_valid;
        logic ld_last;
        logic q_err;
        logic div_last;
        logic srch_done;
    } rpp_stat_t;

endpackage

FILE: src/rpp_ctrl.sv
// ----------------------------------------------------------------------------
// rpp_ctrl
// Sequencer for loads and queries; owns the output valid flag.
// ----------------------------------------------------------------------------
module rpp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rpp_pkg::rpp_stat_t stat,
    output rpp_pkg::rpp_cmd_t  cmd
);
    import rpp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LD_WRITE,
        S_LD_CLOSE,
        S_DIV,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_RD_NX,
        S_POS_X,
        S_POS_Y,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_query)
                begin
                    err_next = stat.q_err;
                    if (stat.q_err)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.div_init  = 1'b1;
                        cmd.srch_init = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (stat.ld_valid)
                begin
                    cmd.ld_read = 1'b1;
                    state_next  = S_LD_WRITE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LD_WRITE:
            begin
                cmd.ld_write = 1'b1;
                state_next   = stat.ld_last ? S_LD_CLOSE : S_IDLE;
            end
            S_LD_CLOSE:
            begin
                cmd.ld_close = 1'b1;
                state_next   = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (stat.srch_done)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_RD_NX;
                end
                else
                begin
                    cmd.srch_read = 1'b1;
                    state_next    = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_update = 1'b1;
                state_next      = S_SRCH_CHK;
            end
            S_RD_NX:
            begin
                cmd.rd_nx  = 1'b1;
                state_next = S_POS_X;
            end
            S_POS_X:
            begin
                cmd.pos_x  = 1'b1;
                state_next = S_POS_Y;
            end
            S_POS_Y:
            begin
                cmd.pos_y  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_err    = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/rpp_datapath.sv
// ----------------------------------------------------------------------------
// rpp_datapath
// Vertex and running-length stores, restoring modulo unit, binary search
// registers and the final step along the segment.
// ----------------------------------------------------------------------------
module rpp_datapath
#(
    parameter int MAX_VERTICES = rpp_pkg::DEF_MAX_VERTICES
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rpp_pkg::rpp_cmd_t                  cmd,
    output rpp_pkg::rpp_stat_t                 stat,
    input  logic                               cfg_wr_en,
    input  logic [rpp_pkg::CNT_BITS-1:0]       cfg_wr_data,
    input  logic                               in_action,
    input  logic [rpp_pkg::IDX_BITS-1:0]       in_index,
    input  logic [rpp_pkg::COORD_BITS-1:0]     in_x,
    input  logic [rpp_pkg::COORD_BITS-1:0]     in_y,
    input  logic [rpp_pkg::TIME_BITS-1:0]      in_time,
    output logic [rpp_pkg::COORD_BITS-1:0]     out_x,
    output logic [rpp_pkg::COORD_BITS-1:0]     out_y,
    output logic                               out_status
);
    import rpp_pkg::*;

    localparam int AW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = (AW + 1 > CNT_BITS) ? AW + 1 : CNT_BITS;
    localparam int CW = COORD_BITS + 1;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_VERTICES);

    function automatic logic [CW:0] seg_len(
        input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by
    );
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic        [CW-1:0] adx;
        logic        [CW-1:0] ady;
        dx  = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
        dy  = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});
        adx = dx[CW-1] ? CW'(-dx) : CW'(dx);
        ady = dy[CW-1] ? CW'(-dy) : CW'(dy);
        return {1'b0, adx} + {1'b0, ady};
    endfunction

    // Configuration and path state
    logic [CNT_BITS-1:0]   vcount_reg;
    logic                  loaded_reg;
    logic [LEN_BITS-1:0]   perim_reg;

    // Captured item
    logic                  act_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [COORD_BITS-1:0] xin_reg;
    logic [COORD_BITS-1:0] yin_reg;
    logic [TIME_BITS-1:0]  time_reg;

    // Stores
    logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];
    logic [LEN_BITS-1:0]     len_mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] vtx_rd_reg;
    logic [LEN_BITS-1:0]     len_rd_reg;
    logic [AW-1:0]           vtx_raddr;
    logic [AW-1:0]           len_raddr;

    // Load working registers
    logic [LEN_BITS-1:0]   run_reg;
    logic [COORD_BITS-1:0] v0x_reg;
    logic [COORD_BITS-1:0] v0y_reg;

    // Modulo unit
    logic [LEN_BITS-1:0]   rem_reg;
    logic [TIME_BITS-1:0]  tsh_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [LEN_BITS:0]     div_shift;
    logic [LEN_BITS:0]     div_diff;

    // Search and position
    logic [NW-1:0]         lo_reg;
    logic [NW-1:0]         hi_reg;
    logic [NW-1:0]         mid_reg;
    logic [NW:0]           mid_sum;
    logic [NW-1:0]         mid;
    logic [NW-1:0]         lo_inc;
    logic [NW-1:0]         nx;
    logic [COORD_BITS-1:0] x0_reg;
    logic [COORD_BITS-1:0] y0_reg;
    logic [LEN_BITS-1:0]   lenlo_reg;
    logic [LEN_BITS-1:0]   rem2_reg;
    logic signed [CW-1:0]  dy_reg;
    logic [COORD_BITS-1:0] posx_reg;
    logic [COORD_BITS-1:0] posy_reg;

    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_status_reg;

    // Derived values
    logic [NW-1:0]         n_act;
    logic [NW-1:0]         idx_n;
    logic [NW-1:0]         prev_n;
    logic [LEN_BITS-1:0]   running;
    logic [LEN_BITS-1:0]   close_len;
    logic [COORD_BITS-1:0] nxx;
    logic [COORD_BITS-1:0] nxy;
    logic [LEN_BITS-1:0]   rem_t;
    logic signed [CW-1:0]  dx;
    logic [CW-1:0]         adx;
    logic [CW-1:0]         ady;
    logic [CW-1:0]         ystep;
    logic signed [CW-1:0]  xsum;
    logic signed [CW-1:0]  ysum;

    always_comb
    begin
        n_act  = ({{(NW-CNT_BITS){1'b0}}, vcount_reg} < MAX_N)
               ? {{(NW-CNT_BITS){1'b0}}, vcount_reg} : MAX_N;
        idx_n  = {{(NW-IDX_BITS){1'b0}}, idx_reg};
        prev_n = idx_n - NW'(1);

        stat.is_query  = (act_reg == ACT_QUERY);
        stat.ld_valid  = (idx_n < n_act);
        stat.ld_last   = (idx_n == n_act - NW'(1));
        stat.q_err     = !loaded_reg || (perim_reg == '0) || (n_act == '0);
        stat.div_last  = (step_reg == STEP_BITS'(TIME_BITS - 1));
        stat.srch_done = (lo_reg == hi_reg);

        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (NW+1)'(1);
        mid     = mid_sum[NW:1];
        lo_inc  = lo_reg + NW'(1);
        nx      = (lo_inc >= n_act) ? '0 : lo_inc;

        if (cmd.ld_read)
        begin
            vtx_raddr = prev_n[AW-1:0];
            len_raddr = prev_n[AW-1:0];
        end
        else if (cmd.rd_nx)
        begin
            vtx_raddr = nx[AW-1:0];
            len_raddr = mid[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            vtx_raddr = lo_reg[AW-1:0];
            len_raddr = lo_reg[AW-1:0];
        end
        else
        begin
            vtx_raddr = lo_reg[AW-1:0];
            len_raddr = mid[AW-1:0];
        end

        running = (idx_reg == '0) ? '0
                : len_rd_reg + LEN_BITS'(seg_len(vtx_rd_reg[COORD_BITS-1:0],
                                                 vtx_rd_reg[2*COORD_BITS-1:COORD_BITS],
                                                 xin_reg, yin_reg));
        close_len = run_reg + LEN_BITS'(seg_len(xin_reg, yin_reg, v0x_reg, v0y_reg));

        div_shift = {rem_reg, tsh_reg[TIME_BITS-1]};
        div_diff  = div_shift - {1'b0, perim_reg};

        nxx   = vtx_rd_reg[COORD_BITS-1:0];
        nxy   = vtx_rd_reg[2*COORD_BITS-1:COORD_BITS];
        rem_t = rem_reg - lenlo_reg;
        dx    = $signed({nxx[COORD_BITS-1], nxx}) - $signed({x0_reg[COORD_BITS-1], x0_reg});
        adx   = dx[CW-1] ? CW'(-dx) : CW'(dx);
        xsum  = dx[CW-1] ? $signed({x0_reg[COORD_BITS-1], x0_reg}) - $signed(rem_t[CW-1:0])
                         : $signed({x0_reg[COORD_BITS-1], x0_reg}) + $signed(rem_t[CW-1:0]);
        ady   = dy_reg[CW-1] ? CW'(-dy_reg) : CW'(dy_reg);
        ystep = (rem2_reg > {{(LEN_BITS-CW){1'b0}}, ady}) ? ady : rem2_reg[CW-1:0];
        ysum  = dy_reg[CW-1] ? $signed({y0_reg[COORD_BITS-1], y0_reg}) - $signed(ystep)
                             : $signed({y0_reg[COORD_BITS-1], y0_reg}) + $signed(ystep);
    end

    // Stores: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_write)
        begin
            vtx_mem[idx_n[AW-1:0]] <= {yin_reg, xin_reg};
            len_mem[idx_n[AW-1:0]] <= running;
        end
        vtx_rd_reg <= vtx_mem[vtx_raddr];
        len_rd_reg <= len_mem[len_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= CNT_RESET;
            loaded_reg     <= 1'b0;
            perim_reg      <= '0;
            act_reg        <= ACT_LOAD;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
                loaded_reg <= 1'b0;
            end
            if (cmd.capture)
            begin
                act_reg <= in_action;
            end
            if (cmd.ld_write)
            begin
                loaded_reg <= 1'b0;
            end
            if (cmd.ld_close)
            begin
                perim_reg  <= close_len;
                loaded_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= in_index;
            xin_reg  <= in_x;
            yin_reg  <= in_y;
            time_reg <= in_time;
        end
        if (cmd.ld_write)
        begin
            run_reg <= running;
            if (idx_reg == '0)
            begin
                v0x_reg <= xin_reg;
                v0y_reg <= yin_reg;
            end
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            tsh_reg  <= time_reg;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_diff[LEN_BITS] ? div_shift[LEN_BITS-1:0]
                                           : div_diff[LEN_BITS-1:0];
            tsh_reg  <= {tsh_reg[TIME_BITS-2:0], 1'b0};
            step_reg <= step_reg + STEP_BITS'(1);
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= n_act - NW'(1);
        end
        if (cmd.srch_read)
        begin
            mid_reg <= mid;
        end
        if (cmd.srch_update)
        begin
            if (len_rd_reg <= rem_reg)
            begin
                lo_reg <= mid_reg;
            end
            else
            begin
                hi_reg <= mid_reg - NW'(1);
            end
        end
        if (cmd.rd_nx)
        begin
            x0_reg    <= vtx_rd_reg[COORD_BITS-1:0];
            y0_reg    <= vtx_rd_reg[2*COORD_BITS-1:COORD_BITS];
            lenlo_reg <= len_rd_reg;
        end
        if (cmd.pos_x)
        begin
            dy_reg <= $signed({nxy[COORD_BITS-1], nxy}) - $signed({y0_reg[COORD_BITS-1], y0_reg});
            if (rem_t <= {{(LEN_BITS-CW){1'b0}}, adx})
            begin
                posx_reg <= xsum[COORD_BITS-1:0];
                rem2_reg <= '0;
            end
            else
            begin
                posx_reg <= nxx;
                rem2_reg <= rem_t - {{(LEN_BITS-CW){1'b0}}, adx};
            end
        end
        if (cmd.pos_y)
        begin
            posy_reg <= ysum[COORD_BITS-1:0];
        end
        if (cmd.out_load)
        begin
            out_x_reg      <= cmd.out_err ? '0 : posx_reg;
            out_y_reg      <= cmd.out_err ? '0 : posy_reg;
            out_status_reg <= cmd.out_err ? STATUS_ERR : STATUS_OK;
        end
    end

    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_status = out_status_reg;

endmodule

FILE: src/rectilinear_path_position.sv
// ----------------------------------------------------------------------------
// rectilinear_path_position
// Position on a closed axis-aligned path at a given distance along it.
// ----------------------------------------------------------------------------
// Usage. Items enter on the slave stream. s_axis_tuser selects the action:
// a load writes one vertex and produces no result; a query produces exactly
// one result transaction on the master stream with the point on the path.
// Vertices are loaded from index 0 upwards; loading the last index (set by
// the vertex count register) closes the path and computes its perimeter.
// A query before the path is closed, or with a zero perimeter, returns
// status 1 and a zero position.
// Sequence. A load is captured, decoded and written to the stores; the last
// vertex adds a step that closes the path. A query runs the bit-serial
// modulo unit, then a binary search of the running-length store, each probe
// a read through its registered port followed by a compare, then reads both
// segment ends and steps along the segment. Items are taken one at a
// time; s_axis_tready is high only while the sequencer is idle.
// A finished result sits in the output register, so a stalled receiver does
// not stop the next item being accepted; only a second result waits for it.
// Reset clears control state, the register (to 4 vertices) and the loaded
// flag; the stores are not cleared and must be loaded before use.
// Writing the vertex count clears the loaded flag.
// ----------------------------------------------------------------------------
module rectilinear_path_position
#(
    parameter int MAX_VERTICES = rpp_pkg::DEF_MAX_VERTICES
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Vertex count register write.
    input  logic                         cfg_wr_en,
    input  logic [rpp_pkg::CNT_BITS-1:0] cfg_wr_data,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // vertex_index[9:0], vertex_x[25:10], vertex_y[41:26], query_time[72:42], zero pad
    input  logic [79:0]                  s_axis_tdata,
    // action[0]
    input  logic                         s_axis_tuser,
    // Output stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // pos_x[15:0], pos_y[31:16]
    output logic [31:0]                  m_axis_tdata,
    // status[0]
    output logic                         m_axis_tuser
);
    import rpp_pkg::*;

    rpp_cmd_t              cmd;
    rpp_stat_t             stat;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  status;

    // Field unpacking of the input transaction.
    logic [IDX_BITS-1:0]   vertex_index;
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic [TIME_BITS-1:0]  query_time;

    assign vertex_index = s_axis_tdata[IDX_BITS-1:0];
    assign vertex_x     = s_axis_tdata[IDX_BITS+COORD_BITS-1:IDX_BITS];
    assign vertex_y     = s_axis_tdata[IDX_BITS+2*COORD_BITS-1:IDX_BITS+COORD_BITS];
    assign query_time   = s_axis_tdata[IDX_BITS+2*COORD_BITS+TIME_BITS-1:
                                       IDX_BITS+2*COORD_BITS];

    rpp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpp_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_axis_tuser),
        .in_index    (vertex_index),
        .in_x        (vertex_x),
        .in_y        (vertex_y),
        .in_time     (query_time),
        .out_x       (pos_x),
        .out_y       (pos_y),
        .out_status  (status)
    );

    // The result register in the datapath holds the transaction until taken.
    assign m_axis_tdata = {pos_y, pos_x};
    assign m_axis_tuser = status;

endmodule
